// ===== rtl/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// Shared command codes, status codes and scan state for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned MAX_FIRE = 16;

  typedef enum logic [2:0] {
    K_SCHED    = 3'd0,
    K_CAN_ID   = 3'd1,
    K_CAN_TYPE = 3'd2,
    K_EXISTS   = 3'd3,
    K_POSTPONE = 3'd4,
    K_TICK     = 3'd5,
    K_CLEAR    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_APPLY = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

// ===== rtl/teq_mem.sv =====
// ----------------------------------------------------------------------------
// teq_mem
// Entry store: one synchronous-read memory holding id, type, code, due time,
// period and rank of each entry. Valid bits live in the controller.
// ----------------------------------------------------------------------------
module teq_mem #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [16+8+16+2*TIME_BITS+32-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [16+8+16+2*TIME_BITS+32-1:0] rdata
);
  localparam int W = 16 + 8 + 16 + 2 * TIME_BITS + 32;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/timed_event_queue.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue
// Table of timed events ordered by due time, then by insertion rank.
// ----------------------------------------------------------------------------
// Every lookup command sweeps the entry memory once, one entry a cycle through
// the single read port, then passes the drain and decide states before its
// result is registered. Schedule picks the lowest free entry from the valid
// flops and needs no sweep; schedule, clear and unknown commands answer the
// next cycle. A tick sweeps once per fired event and once more to learn whether
// anything else is due; at the cap of 16 firings that last sweep is skipped.
// Each firing is held one sweep behind so the final one can carry last, and a
// sweep waits in drain until the previous firing has been taken. The result
// register holds a finished transaction until taken; the next item is taken
// once the last result of the previous one has left. Valid bits are cleared at
// reset and by clear.
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] event_id,
  input  logic        id_given,
  input  logic [7:0]  event_type,
  input  logic [15:0] code_handle,
  input  logic [31:0] time_value,
  input  logic [31:0] interval,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        found,
  output logic [15:0] result_id,
  output logic [7:0]  result_type,
  output logic [15:0] result_code,
  output logic        last
);
  localparam int AW = $clog2(DEPTH);
  localparam int TB = TIME_BITS;
  localparam int W  = 16 + 8 + 16 + 2 * TB + 32;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = $clog2(MAX_FIRE + 1);

  state_t            state;
  logic [DEPTH-1:0]  valid;
  logic [31:0]       order_counter;
  logic [15:0]       next_auto_id;

  // latched command
  logic [2:0]  c_kind;
  logic [15:0] c_id;
  logic [7:0]  c_type;
  logic [TB-1:0] c_tv;

  // sweep
  logic [CW-1:0] rcnt;     // read address counter
  logic          rv;       // read data valid this cycle
  logic [AW-1:0] raddr_q;  // address of data on rdata
  logic          hit;
  logic [AW-1:0] best;
  logic [TB-1:0] best_due;
  logic [31:0]   best_ord;
  logic [W-1:0]  best_data;
  logic [FW-1:0] nfire;
  logic          any;

  // firing held back until the next sweep tells whether it is the last
  logic [15:0]   p_id;
  logic [7:0]    p_type;
  logic [15:0]   p_code;

  logic          we;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [AW-1:0] raddr;
  logic [W-1:0]  rdata;

  teq_mem #(.DEPTH(DEPTH), .TIME_BITS(TB)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // field slices of a memory word: id, type, code, due, period, rank
  logic [15:0]   r_id;
  logic [7:0]    r_type;
  logic [15:0]   r_code;
  logic [TB-1:0] r_due;
  logic [TB-1:0] r_per;
  logic [31:0]   r_ord;
  assign {r_id, r_type, r_code, r_due, r_per, r_ord} = rdata;

  logic [15:0]   b_id;
  logic [7:0]    b_type;
  logic [15:0]   b_code;
  logic [TB-1:0] b_due_w;
  logic [TB-1:0] b_per;
  logic [31:0]   b_ord;
  assign {b_id, b_type, b_code, b_due_w, b_per, b_ord} = best_data;

  // lowest free entry
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic [TB-1:0] tv_in;
  logic [TB-1:0] per_in;
  assign tv_in  = TB'(time_value);
  assign per_in = TB'(interval);

  logic is_cand;
  logic earlier_c;
  always_comb begin
    is_cand = rv && valid[raddr_q];
    case (c_kind)
      K_CAN_ID, K_EXISTS, K_POSTPONE: is_cand = is_cand && (r_id == c_id);
      K_CAN_TYPE:                     is_cand = is_cand && (r_type == c_type);
      default:                        ;
    endcase
    earlier_c = (r_due < best_due) || ((r_due == best_due) && (r_ord < best_ord));
  end

  assign raddr    = rcnt[AW-1:0];
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == S_IDLE && in_valid && in_ready && kind_t'(kind) == K_SCHED) begin
      we    = free_any;
      waddr = free_idx;
      wdata = {(id_given ? event_id : next_auto_id), event_type, code_handle,
               tv_in, per_in, order_counter + 32'd1};
    end else if (state == S_APPLY && hit) begin
      // write back a postponed entry, or a periodic entry that fires now
      we    = (c_kind == K_POSTPONE) ||
              (c_kind == K_TICK && b_per != '0 && b_due_w <= c_tv);
      waddr = best;
      wdata = {b_id, b_type, b_code,
               (c_kind == K_POSTPONE) ? (b_due_w + c_tv) : (c_tv + b_per),
               b_per, b_ord};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      order_counter <= '0;
      next_auto_id  <= '0;
      out_valid     <= 1'b0;
      rv            <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            c_kind <= kind;
            c_id   <= event_id;
            c_type <= event_type;
            c_tv   <= tv_in;
            nfire  <= '0;
            status <= ST_OK;
            found  <= 1'b0;
            result_id   <= '0;
            result_type <= '0;
            result_code <= '0;
            last   <= 1'b1;
            case (kind_t'(kind))
              K_SCHED: begin
                out_valid <= 1'b1;
                if (free_any) begin
                  valid[free_idx] <= 1'b1;
                  order_counter   <= order_counter + 32'd1;
                  if (!id_given) next_auto_id <= next_auto_id + 16'd1;
                  result_id <= id_given ? event_id : next_auto_id;
                end else begin
                  status <= ST_FULL;
                end
              end
              K_CLEAR: begin
                valid     <= '0;
                out_valid <= 1'b1;
              end
              K_CAN_ID, K_CAN_TYPE, K_EXISTS, K_POSTPONE, K_TICK: begin
                rcnt  <= '0;
                hit   <= 1'b0;
                any   <= 1'b0;
                state <= S_SCAN;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          // issue one read a cycle; compare the word read the cycle before
          rv      <= 1'b1;
          raddr_q <= raddr;
          rcnt    <= rcnt + CW'(1);
          if (rcnt == CW'(DEPTH - 1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          // hold until the last word is compared and the held firing is taken
          rv <= 1'b0;
          if (!rv && !out_valid) state <= S_APPLY;
        end
        S_APPLY: begin
          case (c_kind)
            K_CAN_ID, K_CAN_TYPE: begin
              status    <= any ? ST_OK : ST_NOTFOUND;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
            K_EXISTS, K_POSTPONE: begin
              status    <= hit ? ST_OK : ST_NOTFOUND;
              found     <= hit;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
            default: begin // tick
              if (hit && b_due_w <= c_tv) begin
                if (b_per == '0) valid[best] <= 1'b0;
                p_id   <= b_id;
                p_type <= b_type;
                p_code <= b_code;
                nfire  <= nfire + FW'(1);
                if (nfire != '0) begin
                  // another firing follows: release the held one as not last
                  status      <= ST_OK;
                  result_id   <= p_id;
                  result_type <= p_type;
                  result_code <= p_code;
                  last        <= 1'b0;
                  out_valid   <= 1'b1;
                end
                if (nfire == FW'(MAX_FIRE - 1)) begin
                  state <= S_OUT;
                end else begin
                  rcnt  <= '0;
                  hit   <= 1'b0;
                  state <= S_SCAN;
                end
              end else if (nfire == '0) begin
                // nothing due at all: close the transaction
                status      <= ST_NONE;
                result_id   <= '0;
                result_type <= '0;
                result_code <= '0;
                last        <= 1'b1;
                out_valid   <= 1'b1;
                state       <= S_IDLE;
              end else begin
                state <= S_OUT;
              end
            end
          endcase
        end
        S_OUT: begin
          // the held firing becomes last once the one before it has left
          if (!out_valid) begin
            status      <= ST_OK;
            result_id   <= p_id;
            result_type <= p_type;
            result_code <= p_code;
            last        <= 1'b1;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // per-word sweep action
      if (is_cand) begin
        case (c_kind)
          K_CAN_ID, K_CAN_TYPE: begin
            valid[raddr_q] <= 1'b0;
            any            <= 1'b1;
          end
          default: begin
            if (!hit || earlier_c) begin
              hit       <= 1'b1;
              best      <= raddr_q;
              best_due  <= r_due;
              best_ord  <= r_ord;
              best_data <= rdata;
            end
          end
        endcase
      end
    end
  end
endmodule

// ===== rtl/teq_checker.sv =====
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks of the timed event queue.
// ----------------------------------------------------------------------------
module teq_checker
  import teq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        found,
  input logic        last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK && last)
    else $error("found without ok status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind timed_event_queue teq_checker u_teq_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .status, .found, .last
);

// ===== tb/sv/tb_timed_event_queue.sv =====
// ----------------------------------------------------------------------------
// tb_timed_event_queue
// Self-checking bench for the timed event queue: directed and random commands
// and ticks, checked result by result against a behavioral table model.
// ----------------------------------------------------------------------------
module tb_timed_event_queue;
  import teq_pkg::*;

  localparam int NSLOT     = 16;
  localparam int CYC_LIMIT = 1500000;
  localparam logic [2:0] K_UNUSED = 3'd7;  // kind with no command behind it

  typedef struct packed {
    status_t     st;
    logic        fnd;
    logic [15:0] id;
    logic [7:0]  ty;
    logic [15:0] code;
    logic        lst;
  } teq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = '0;
  logic [15:0] event_id = '0;
  logic        id_given = 1'b0;
  logic [7:0]  event_type = '0;
  logic [15:0] code_handle = '0;
  logic [31:0] time_value = '0;
  logic [31:0] interval = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        found;
  logic [15:0] result_id;
  logic [7:0]  result_type;
  logic [15:0] result_code;
  logic        last;

  timed_event_queue dut (.*);

  // Shadow copy of the event table.
  logic        tbl_valid [NSLOT];
  logic [15:0] tbl_id    [NSLOT];
  logic [7:0]  tbl_type  [NSLOT];
  logic [15:0] tbl_code  [NSLOT];
  logic [31:0] tbl_due   [NSLOT];
  logic [31:0] tbl_per   [NSLOT];
  logic [31:0] tbl_rank  [NSLOT];
  logic [31:0] rank_ctr;
  logic [15:0] auto_id;

  // Expected results, written by the sender and read by the checker.
  teq_result_t exp_fifo [64];
  int          exp_wr;
  int          exp_rd;
  int          err_cnt;
  int          cyc;
  logic        sink_busy;   // drives random stall on the result side
  int          time_base;   // rough "now" used by random ticks

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit fires_before(int a, int b);
    if (tbl_due[a] != tbl_due[b]) return tbl_due[a] < tbl_due[b];
    return tbl_rank[a] < tbl_rank[b];
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_valid[i] && (best < 0 || fires_before(i, best))) best = i;
    return best;
  endfunction

  function automatic teq_result_t mk(status_t st, logic f, logic [15:0] id,
                                     logic [7:0] ty, logic [15:0] cd, logic l);
    teq_result_t r;
    r.st = st; r.fnd = f; r.id = id; r.ty = ty; r.code = cd; r.lst = l;
    return r;
  endfunction

  task automatic queue_result(teq_result_t r);
    exp_fifo[exp_wr[5:0]] = r;
    exp_wr++;
  endtask

  // Apply one transaction to the shadow table and queue what it yields.
  task automatic predict_table(logic [2:0] k, logic [15:0] id, logic giv,
                               logic [7:0] ty, logic [15:0] cd,
                               logic [31:0] tv, logic [31:0] per);
    int slot;
    int hit;
    int n;
    int e;
    bit any;
    logic [15:0] nid;
    slot = -1; hit = -1; n = 0; any = 1'b0;
    case (k)
      K_SCHED: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          queue_result(mk(ST_FULL, 1'b0, 16'd0, 8'd0, 16'd0, 1'b1));
        end else begin
          if (giv) nid = id;
          else begin
            nid = auto_id;
            auto_id++;
          end
          rank_ctr++;
          tbl_valid[slot] = 1'b1; tbl_id[slot] = nid; tbl_type[slot] = ty;
          tbl_code[slot] = cd; tbl_due[slot] = tv; tbl_per[slot] = per;
          tbl_rank[slot] = rank_ctr;
          queue_result(mk(ST_OK, 1'b0, nid, 8'd0, 16'd0, 1'b1));
        end
      end
      K_CAN_ID, K_CAN_TYPE: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_valid[i] &&
              ((k == K_CAN_ID) ? tbl_id[i] == id : tbl_type[i] == ty)) begin
            tbl_valid[i] = 1'b0;
            any = 1'b1;
          end
        queue_result(mk(any ? ST_OK : ST_NOTFOUND, 1'b0, 16'd0, 8'd0, 16'd0, 1'b1));
      end
      K_EXISTS, K_POSTPONE: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_valid[i] && tbl_id[i] == id && (hit < 0 || fires_before(i, hit)))
            hit = i;
        if (hit >= 0 && k == K_POSTPONE) tbl_due[hit] = tbl_due[hit] + tv;
        queue_result(mk(hit >= 0 ? ST_OK : ST_NOTFOUND, hit >= 0,
                        16'd0, 8'd0, 16'd0, 1'b1));
      end
      K_TICK: begin
        while (n < MAX_FIRE) begin
          e = earliest_slot();
          if (e < 0 || tbl_due[e] > tv) break;
          queue_result(mk(ST_OK, 1'b0, tbl_id[e], tbl_type[e], tbl_code[e], 1'b0));
          n++;
          if (tbl_per[e] != 0) tbl_due[e] = tv + tbl_per[e];
          else tbl_valid[e] = 1'b0;
        end
        if (n == 0) queue_result(mk(ST_NONE, 1'b0, 16'd0, 8'd0, 16'd0, 1'b1));
        else exp_fifo[6'(exp_wr - 1)].lst = 1'b1;
      end
      K_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
        queue_result(mk(ST_OK, 1'b0, 16'd0, 8'd0, 16'd0, 1'b1));
      end
      default: queue_result(mk(ST_OK, 1'b0, 16'd0, 8'd0, 16'd0, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR cycle %0d: %s got %0h want %0h", cyc, what, got, want);
    err_cnt++;
  endtask

  // Send one transaction; hold valid and payload until accepted.
  task automatic send_cmd(logic [2:0] k, logic [15:0] id = '0, logic giv = 1'b1,
                          logic [7:0] ty = '0, logic [15:0] cd = '0,
                          logic [31:0] tv = '0, logic [31:0] per = '0);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; event_id <= id; id_given <= giv;
    event_type <= ty; code_handle <= cd; time_value <= tv; interval <= per;
    do @(posedge clk); while (!in_ready);
    predict_table(k, id, giv, ty, cd, tv, per);
  endtask

  // Result side: random stalls, compare each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected result, status", 32'(status), 32'd0);
        end else begin
          teq_result_t w;
          w = exp_fifo[exp_rd[5:0]];
          exp_rd++;
          if (status != w.st)
            report_mismatch("status", 32'(status), 32'(w.st));
          if (found != w.fnd)
            report_mismatch("found", 32'(found), 32'(w.fnd));
          if (result_id != w.id)
            report_mismatch("result_id", 32'(result_id), 32'(w.id));
          if (result_type != w.ty)
            report_mismatch("result_type", 32'(result_type), 32'(w.ty));
          if (result_code != w.code)
            report_mismatch("result_code", 32'(result_code), 32'(w.code));
          if (last != w.lst)
            report_mismatch("last", 32'(last), 32'(w.lst));
        end
      end
      if (sink_busy) out_ready <= ($urandom_range(0, 9) < 3);
      else out_ready <= 1'b1;
    end
  end

  // Toggle between stretches with and without result-side stalls.
  initial begin
    sink_busy = 1'b0;
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      sink_busy = ~sink_busy;
    end
  end

  task automatic test_edges();
    // Empty table: tick reports nothing due, lookups miss.
    send_cmd(K_TICK, .tv(32'hFFFF_FFFF));
    send_cmd(K_EXISTS, .id(16'hFFFF));
    send_cmd(K_POSTPONE, .id(16'd0), .tv(32'd5));
    send_cmd(K_CAN_ID, .id(16'd0));
    send_cmd(K_CAN_TYPE, .ty(8'hFF));
    send_cmd(K_UNUSED, .id(16'hFFFF), .ty(8'hFF), .cd(16'hFFFF), .tv('1), .per('1));
    // Auto ids, extreme fields, equal due times broken by rank.
    send_cmd(K_SCHED, .giv(1'b0), .ty(8'hFF), .cd(16'hFFFF), .tv(32'd100));
    send_cmd(K_SCHED, .id(16'hFFFF), .ty(8'd0), .cd(16'd0), .tv(32'd100));
    send_cmd(K_SCHED, .giv(1'b0), .ty(8'd3), .cd(16'h5A5A), .tv(32'hFFFF_FFFF),
             .per(32'hFFFF_FFFF));
    send_cmd(K_SCHED, .id(16'd7), .ty(8'd3), .cd(16'd1), .tv(32'd50), .per(32'd30));
    send_cmd(K_EXISTS, .id(16'hFFFF));
    send_cmd(K_POSTPONE, .id(16'd7), .tv(32'hFFFF_FFF0));  // wraps to 34
    send_cmd(K_TICK, .tv(32'd100));
    send_cmd(K_TICK, .tv(32'hFFFF_FFFF));                   // periodic sum wraps
    send_cmd(K_CAN_TYPE, .ty(8'd3));
    // Fill to full, one more is refused, then clear.
    for (int i = 0; i < NSLOT + 1; i++) send_cmd(K_SCHED, .giv(1'b0), .tv(32'(i)));
    send_cmd(K_CLEAR);
    send_cmd(K_TICK, .tv('1));
  endtask

  task automatic test_firing_limit();
    // Periodic events whose next due time wraps below now stay due and run
    // into the firing cap.
    for (int i = 0; i < 4; i++)
      send_cmd(K_SCHED, .id(16'(i)), .ty(8'(i)), .cd(16'(i)), .tv(32'd0), .per(32'd16));
    send_cmd(K_TICK, .tv(32'hFFFF_FFF8));
    send_cmd(K_TICK, .tv(32'hFFFF_FFFF));
    send_cmd(K_CLEAR);
  endtask

  task automatic test_random(int count);
    int r;
    logic [2:0] k;
    logic [31:0] tv;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) k = K_SCHED;
      else if (r < 65) k = K_TICK;
      else if (r < 72) k = K_CAN_ID;
      else if (r < 78) k = K_CAN_TYPE;
      else if (r < 86) k = K_EXISTS;
      else if (r < 94) k = K_POSTPONE;
      else if (r < 97) k = K_CLEAR;
      else k = K_UNUSED;
      // Small ids and types make hits likely; now and then use any value.
      if (k == K_TICK) begin
        time_base = time_base + $urandom_range(0, 40);
        tv = ($urandom_range(0, 19) == 0) ? $urandom() : time_base;
      end else if (k == K_SCHED) begin
        tv = ($urandom_range(0, 9) == 0) ? $urandom() : time_base + $urandom_range(0, 80);
      end else begin
        tv = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 30);
      end
      send_cmd(k,
               ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)),
               ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3)),
               16'($urandom()), tv,
               ($urandom_range(0, 2) == 0) ? 32'd0 :
               (($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 60)));
    end
  endtask

  initial begin
    time_base = 0;
    rank_ctr = 0;
    auto_id = 0;
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_edges();
    test_firing_limit();
    test_random(160);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && exp_wr == exp_rd) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
